[rtl/lps_pkg.sv]
// Shared declarations for the line pixel stepper.
// Holds the item kind codes and the command queue geometry; no dependencies.
`default_nettype none

package lps_pkg;

  // Item kinds carried on the input tuser bit and inside queued commands.
  typedef enum logic {
    KIND_START = 1'b0,
    KIND_NEXT  = 1'b1
  } kind_t;

  // Command queue between the classifier and the stepper.
  localparam int QUEUE_AW    = 2;
  localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

endpackage

`default_nettype wire

[rtl/line_pixel_stepper_core.sv]
// An input word is written into the command queue, then popped into the registered output word.
// Throughput: one word per cycle on both sides; the stepper adds and compares once per pixel.
// A four-entry command queue lets input keep flowing while the output is stalled, until it fills.
// Reset (rst, synchronous, active high) empties the queue, drops the output word and
// clears the line state, so no line is active after reset.
// Top level of the line pixel stepper; instantiates lps_front, lps_fifo and lps_back.
`default_nettype none

module line_pixel_stepper_core #(
  parameter int COORD_BITS = 10
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  // Input stream: tdata holds x_start, y_start, x_end, y_end from bit 0 up.
  input  wire logic                                  s_tvalid,
  output logic                                       s_tready,
  input  wire logic [((4*COORD_BITS+7)/8)*8-1:0]     s_tdata,   // x_start, y_start, x_end, y_end
  input  wire logic                                  s_tuser,   // kind
  // Output stream: tdata holds pixel_x, pixel_y from bit 0 up.
  output logic                                       m_tvalid,
  input  wire logic                                  m_tready,
  output logic [((2*COORD_BITS+7)/8)*8-1:0]          m_tdata,   // pixel_x, pixel_y
  output logic                                       m_tuser,   // pixel_valid
  output logic                                       m_tlast    // last
);

  localparam int IN_W  = ((4 * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_W = ((2 * COORD_BITS + 7) / 8) * 8;
  // A command holds the kind, five axis-ordered coordinates and deltas,
  // the two step directions and the axis-swap flag.
  localparam int CMD_W = 4 + 5 * COORD_BITS;

  logic             q_push;
  logic             q_full;
  logic [CMD_W-1:0] q_in;
  logic             q_not_empty;
  logic             q_pop;
  logic [CMD_W-1:0] q_out;

  // The front end works out absolute deltas, step signs and which axis is
  // major for every start word, so the stepper only adds and compares.
  lps_front #(
    .COORD_BITS (COORD_BITS),
    .IN_W       (IN_W),
    .CMD_W      (CMD_W)
  ) u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_in)
  );

  // The queue lets the input side keep accepting while the output is stalled.
  lps_fifo #(
    .WIDTH (CMD_W)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_data  (q_out)
  );

  // The back end holds the running Bresenham state and issues one result word per
  // command into its output register, which is refilled in the cycle it drains.
  lps_back #(
    .COORD_BITS (COORD_BITS),
    .CMD_W      (CMD_W),
    .OUT_W      (OUT_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_not_empty),
    .cmd_ready (q_pop),
    .cmd_data  (q_out),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

`default_nettype wire

[rtl/lps_front.sv]
// Front end of the line pixel stepper: accepts input words and classifies them.
// Start words are turned into major/minor axis commands; no package dependencies.
`default_nettype none

module lps_front #(
  parameter int COORD_BITS = 10,
  parameter int IN_W       = 40,
  parameter int CMD_W      = 4 + 5 * COORD_BITS
) (
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire logic [IN_W-1:0]  s_tdata,   // x_start, y_start, x_end, y_end
  input  wire logic             s_tuser,   // kind
  input  wire logic             q_full,
  output logic                  q_push,
  output logic [CMD_W-1:0]      q_data
);

  localparam int C = COORD_BITS;

  logic [C-1:0] xs, ys, xe, ye;
  logic [C-1:0] dx, dy;
  logic         xd, yd, swap;
  logic         kind;

  assign xs   = s_tdata[C-1:0];
  assign ys   = s_tdata[2*C-1:C];
  assign xe   = s_tdata[3*C-1:2*C];
  assign ye   = s_tdata[4*C-1:3*C];
  assign kind = s_tuser;

  assign xd   = (xe < xs);
  assign yd   = (ye < ys);
  assign dx   = xd ? (xs - xe) : (xe - xs);
  assign dy   = yd ? (ys - ye) : (ye - ys);
  // A y delta strictly larger than the x delta makes y the major axis.
  assign swap = (dy > dx);

  assign s_tready = !q_full;
  assign q_push   = s_tvalid && !q_full;

  always_comb begin
    if (swap) begin
      q_data = {swap, xd, yd, dx, dy, ye, xs, ys, kind};
    end else begin
      q_data = {swap, yd, xd, dy, dx, xe, ys, xs, kind};
    end
  end

endmodule

`default_nettype wire

[rtl/lps_fifo.sv]
// Small command queue that decouples the classifier from the stepper.
// First-word fall-through register queue; depth comes from lps_pkg.
`default_nettype none

module lps_fifo #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic                  not_empty,
  output logic [WIDTH-1:0]      pop_data
);

  localparam int AW = lps_pkg::QUEUE_AW;

  logic [WIDTH-1:0] mem [lps_pkg::QUEUE_DEPTH];
  logic [AW:0]      wr_ptr;
  logic [AW:0]      rd_ptr;

  assign not_empty = (wr_ptr != rd_ptr);
  assign full      = (wr_ptr[AW] != rd_ptr[AW]) && (wr_ptr[AW-1:0] == rd_ptr[AW-1:0]);
  assign pop_data  = mem[rd_ptr[AW-1:0]];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= wr_ptr + (AW+1)'(1);
      end
      if (pop && not_empty) begin
        rd_ptr <= rd_ptr + (AW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr[AW-1:0]] <= push_data;
    end
  end

endmodule

`default_nettype wire

[rtl/lps_back.sv]
// Back end of the line pixel stepper: holds the line state and steps it.
// Pops queued commands and drives the registered output word; uses lps_pkg.
`default_nettype none

module lps_back #(
  parameter int COORD_BITS = 10,
  parameter int CMD_W      = 4 + 5 * COORD_BITS,
  parameter int OUT_W      = 24
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cmd_valid,
  output logic                  cmd_ready,
  input  wire logic [CMD_W-1:0] cmd_data,
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic [OUT_W-1:0]      m_tdata,   // pixel_x, pixel_y
  output logic                  m_tuser,   // pixel_valid
  output logic                  m_tlast    // last
);

  localparam int C     = COORD_BITS;
  localparam int EB    = COORD_BITS + 2;
  localparam int MAJP  = 1;
  localparam int MINP  = 1 + C;
  localparam int MAJE  = 1 + 2 * C;
  localparam int MAJD  = 1 + 3 * C;
  localparam int MIND  = 1 + 4 * C;
  localparam int MAJDR = 1 + 5 * C;
  localparam int MINDR = 2 + 5 * C;
  localparam int SWP   = 3 + 5 * C;

  logic [C-1:0]         major_pos, major_pos_next;
  logic [C-1:0]         minor_pos, minor_pos_next;
  logic [C-1:0]         major_end, major_end_next;
  logic [C-1:0]         major_delta, major_delta_next;
  logic [C-1:0]         minor_delta, minor_delta_next;
  logic signed [EB-1:0] error_acc, error_acc_next;
  logic                 major_dir, major_dir_next;
  logic                 minor_dir, minor_dir_next;
  logic                 axes_swapped, axes_swapped_next;
  logic                 active, active_next;

  logic [C-1:0]         out_px, out_px_next;
  logic [C-1:0]         out_py, out_py_next;
  logic                 out_pv, out_pv_next;
  logic                 out_last, out_last_next;
  logic                 out_valid, out_valid_next;

  logic                 pop;
  logic                 is_start;
  logic signed [EB-1:0] err_sum;
  logic signed [EB:0]   err_twice;
  logic                 minor_step;
  logic [C-1:0]         step_major;
  logic [C-1:0]         step_minor;
  logic                 hit_end;

  assign cmd_ready = !out_valid || m_tready;
  assign pop       = cmd_valid && cmd_ready;
  assign is_start  = (lps_pkg::kind_t'(cmd_data[0]) == lps_pkg::KIND_START);

  assign step_major = major_dir ? (major_pos - C'(1)) : (major_pos + C'(1));
  assign step_minor = minor_dir ? (minor_pos - C'(1)) : (minor_pos + C'(1));
  assign err_sum    = error_acc + $signed({2'b00, minor_delta});
  assign err_twice  = {err_sum, 1'b0};
  assign minor_step = (err_twice >= $signed({3'b000, major_delta}));
  assign hit_end    = (step_major == major_end);

  always_comb begin
    major_pos_next    = major_pos;
    minor_pos_next    = minor_pos;
    major_end_next    = major_end;
    major_delta_next  = major_delta;
    minor_delta_next  = minor_delta;
    error_acc_next    = error_acc;
    major_dir_next    = major_dir;
    minor_dir_next    = minor_dir;
    axes_swapped_next = axes_swapped;
    active_next       = active;
    out_px_next       = out_px;
    out_py_next       = out_py;
    out_pv_next       = out_pv;
    out_last_next     = out_last;
    out_valid_next    = out_valid && !m_tready;

    if (pop) begin
      out_valid_next = 1'b1;
      if (is_start) begin
        major_pos_next    = cmd_data[MAJP +: C];
        minor_pos_next    = cmd_data[MINP +: C];
        major_end_next    = cmd_data[MAJE +: C];
        major_delta_next  = cmd_data[MAJD +: C];
        minor_delta_next  = cmd_data[MIND +: C];
        major_dir_next    = cmd_data[MAJDR];
        minor_dir_next    = cmd_data[MINDR];
        axes_swapped_next = cmd_data[SWP];
        error_acc_next    = '0;
        out_last_next     = (cmd_data[MAJP +: C] == cmd_data[MAJE +: C]);
        active_next       = !out_last_next;
        out_pv_next       = 1'b1;
        out_px_next       = cmd_data[SWP] ? cmd_data[MINP +: C] : cmd_data[MAJP +: C];
        out_py_next       = cmd_data[SWP] ? cmd_data[MAJP +: C] : cmd_data[MINP +: C];
      end else if (active) begin
        major_pos_next = step_major;
        if (minor_step) begin
          minor_pos_next = step_minor;
          error_acc_next = err_sum - $signed({2'b00, major_delta});
        end else begin
          error_acc_next = err_sum;
        end
        active_next   = !hit_end;
        out_last_next = hit_end;
        out_pv_next   = 1'b1;
        out_px_next   = axes_swapped ? minor_pos_next : step_major;
        out_py_next   = axes_swapped ? step_major : minor_pos_next;
      end else begin
        // No line in progress: the result carries no pixel and all zeros.
        out_pv_next   = 1'b0;
        out_last_next = 1'b0;
        out_px_next   = '0;
        out_py_next   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      major_pos    <= '0;
      minor_pos    <= '0;
      major_end    <= '0;
      major_delta  <= '0;
      minor_delta  <= '0;
      error_acc    <= '0;
      major_dir    <= 1'b0;
      minor_dir    <= 1'b0;
      axes_swapped <= 1'b0;
      active       <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      major_pos    <= major_pos_next;
      minor_pos    <= minor_pos_next;
      major_end    <= major_end_next;
      major_delta  <= major_delta_next;
      minor_delta  <= minor_delta_next;
      error_acc    <= error_acc_next;
      major_dir    <= major_dir_next;
      minor_dir    <= minor_dir_next;
      axes_swapped <= axes_swapped_next;
      active       <= active_next;
      out_valid    <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    out_px   <= out_px_next;
    out_py   <= out_py_next;
    out_pv   <= out_pv_next;
    out_last <= out_last_next;
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = OUT_W'({out_py, out_px});
  assign m_tuser  = out_pv;
  assign m_tlast  = out_last;

  // An empty result never carries coordinates or an end mark.
  a_empty_is_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_pv) |-> (out_px == '0 && out_py == '0 && !out_last))
    else $error("empty result carries nonzero fields");

  // A start command always produces a pixel in the next result.
  a_start_gives_pixel: assert property (@(posedge clk) disable iff (rst)
    (pop && is_start) |=> (out_valid && out_pv))
    else $error("start command did not produce a pixel");

  // The line ends exactly when the end mark is issued.
  a_last_clears_active: assert property (@(posedge clk) disable iff (rst)
    pop |=> (active == (out_pv && !out_last)))
    else $error("active flag disagrees with issued end mark");

  // The error stays within half the major delta on either side.
  a_error_bound: assert property (@(posedge clk) disable iff (rst)
    active |-> ((($signed({error_acc, 1'b0})) <= $signed({3'b000, major_delta})) &&
                (($signed({error_acc, 1'b0})) >= -$signed({3'b000, major_delta}))))
    else $error("error accumulator out of range");

endmodule

`default_nettype wire

[sim/tb_line_pixel_stepper_core.sv]
// Self-checking testbench for line_pixel_stepper_core: directed and random lines in all octants.
// A built-in Bresenham tracker predicts every output word; depends on rtl/lps_pkg.sv and the core.
// Both stream sides idle and stall at random, in calm and busy stretches.
module tb_line_pixel_stepper_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB         = 10;
  localparam int SW         = ((4*CB+7)/8)*8;
  localparam int MW         = ((2*CB+7)/8)*8;
  localparam int COORD_MAX  = (1 << CB) - 1;
  localparam int CYCLE_CAP  = 600000;
  localparam int RAND_WORDS = 1650;

  typedef logic [CB-1:0] coord_t;

  typedef struct packed {
    coord_t px;
    coord_t py;
    logic   valid;
    logic   last;
  } pixel_t;

  // Tracks the line being drawn and keeps the pixels still owed by the core.
  class pixel_ledger;
    pixel_t pending_pixels[$];
    int     errors;
    int     checked;
    coord_t maj_pos, min_pos, maj_end, maj_delta, min_delta;
    int     err_acc;
    bit     maj_dn, min_dn, swapped, active;

    function new();
      errors  = 0;
      checked = 0;
      maj_pos = '0; min_pos = '0; maj_end = '0; maj_delta = '0; min_delta = '0;
      err_acc = 0;
      maj_dn  = 0; min_dn = 0; swapped = 0; active = 0;
    endfunction

    task report(string what);
      errors++;
      if (errors <= 40) $display("MISMATCH at %0t: %s", $realtime, what);
    endtask

    function pixel_t place(bit is_last);
      pixel_t p;
      p.px    = swapped ? min_pos : maj_pos;
      p.py    = swapped ? maj_pos : min_pos;
      p.valid = 1'b1;
      p.last  = is_last;
      return p;
    endfunction

    // Called for every accepted input word.
    function void note_word(lps_pkg::kind_t k, coord_t xs, coord_t ys, coord_t xe, coord_t ye);
      pixel_t p;
      int     dx, dy;
      bit     xd, yd, is_last;
      if (k == lps_pkg::KIND_START) begin
        dx = (xe >= xs) ? int'(xe) - int'(xs) : int'(xs) - int'(xe);
        dy = (ye >= ys) ? int'(ye) - int'(ys) : int'(ys) - int'(ye);
        xd = (xe < xs);
        yd = (ye < ys);
        // Ties stay x-major so that equal deltas give a clean diagonal.
        swapped = (dy > dx);
        if (swapped) begin
          maj_pos = ys; min_pos = xs; maj_end = ye;
          maj_delta = coord_t'(dy); min_delta = coord_t'(dx);
          maj_dn = yd; min_dn = xd;
        end else begin
          maj_pos = xs; min_pos = ys; maj_end = xe;
          maj_delta = coord_t'(dx); min_delta = coord_t'(dy);
          maj_dn = xd; min_dn = yd;
        end
        err_acc = 0;
        is_last = (maj_pos == maj_end);
        active  = !is_last;
        p = place(is_last);
      end else if (!active) begin
        // A next request with no line in progress gives an empty word.
        p = '0;
      end else begin
        maj_pos = maj_dn ? maj_pos - 1'b1 : maj_pos + 1'b1;
        err_acc += int'(min_delta);
        if (2 * err_acc >= int'(maj_delta)) begin
          min_pos = min_dn ? min_pos - 1'b1 : min_pos + 1'b1;
          err_acc -= int'(maj_delta);
        end
        is_last = (maj_pos == maj_end);
        if (is_last) active = 0;
        p = place(is_last);
      end
      pending_pixels.push_back(p);
    endfunction

    // Called for every accepted output word.
    task check_word(logic [MW-1:0] data, logic user, logic lst);
      pixel_t want;
      coord_t got_x, got_y;
      got_x = data[CB-1:0];
      got_y = data[2*CB-1:CB];
      if (pending_pixels.size() == 0) begin
        report($sformatf("output word x=%0d y=%0d with no pixel pending", got_x, got_y));
      end else begin
        want = pending_pixels.pop_front();
        checked++;
        if (got_x !== want.px)
          report($sformatf("word %0d pixel_x got %0d want %0d", checked, got_x, want.px));
        if (got_y !== want.py)
          report($sformatf("word %0d pixel_y got %0d want %0d", checked, got_y, want.py));
        if (user !== want.valid)
          report($sformatf("word %0d pixel_valid got %b want %b", checked, user, want.valid));
        if (lst !== want.last)
          report($sformatf("word %0d last got %b want %b", checked, lst, want.last));
      end
    endtask
  endclass

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          s_tvalid = 1'b0;
  logic          s_tready;
  logic [SW-1:0] s_tdata = '0;
  logic          s_tuser = 1'b0;
  logic          m_tvalid;
  logic          m_tready = 1'b0;
  logic [MW-1:0] m_tdata;
  logic          m_tuser;
  logic          m_tlast;

  pixel_ledger trace = new();
  int          cycle_count = 0;
  int          words_sent = 0;
  int          s_run = 0, m_run = 0;
  bit          s_calm = 0, m_calm = 0;

  line_pixel_stepper_core #(.COORD_BITS(CB)) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Wait cycles come in stretches: some stretches have no idling at all.
  function automatic int draw_wait(inout int run_left, inout bit calm);
    if (run_left == 0) begin
      run_left = $urandom_range(8, 60);
      calm     = ($urandom_range(0, 3) == 0);
    end
    run_left--;
    return calm ? 0 : int'($urandom_range(0, 14));
  endfunction

  function automatic coord_t offset_coord(coord_t base, int delta);
    int v;
    v = int'(base) + delta;
    if (v < 0) v = 0;
    if (v > COORD_MAX) v = COORD_MAX;
    return coord_t'(v);
  endfunction

  function automatic int abs_diff(coord_t a, coord_t b);
    return (a >= b) ? int'(a) - int'(b) : int'(b) - int'(a);
  endfunction

  // Valid is dropped only when a gap follows, so it never toggles within one step.
  task automatic send_word(lps_pkg::kind_t k, logic [SW-1:0] data);
    int gap;
    gap = draw_wait(s_run, s_calm);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= data;
    s_tuser  <= k;
    do @(posedge clk); while (!s_tready);
    trace.note_word(k, data[CB-1:0], data[2*CB-1:CB], data[3*CB-1:2*CB], data[4*CB-1:3*CB]);
    words_sent++;
  endtask

  task automatic send_start(coord_t xs, coord_t ys, coord_t xe, coord_t ye);
    logic [SW-1:0] data;
    data = '0;
    data[4*CB-1:0] = {ye, xe, ys, xs};
    send_word(lps_pkg::KIND_START, data);
  endtask

  // The endpoint bits are ignored on a next request, so they carry noise.
  task automatic send_next();
    send_word(lps_pkg::KIND_NEXT, SW'({8'($urandom), 32'($urandom)}));
  endtask

  task automatic hold_until_drained();
    s_tvalid <= 1'b0;
    while (trace.pending_pixels.size() != 0) @(posedge clk);
  endtask

  // The budget bounds the words of one line, start included, so long lines
  // near the end of the run do not overshoot the word count.
  task automatic send_random_line(int budget);
    int     pick, reach, span, steps;
    coord_t xs, ys, xe, ye;
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      // Edge-to-edge line along one axis, reaching both extremes.
      xs = $urandom_range(0, 1) ? coord_t'(COORD_MAX) : '0;
      xe = ~xs;
      ys = coord_t'($urandom);
      ye = offset_coord(ys, int'($urandom_range(0, 600)) - 300);
      if ($urandom_range(0, 1)) begin
        {xs, ys} = {ys, xs};
        {xe, ye} = {ye, xe};
      end
    end else begin
      reach = (pick < 12) ? 200 : 24;
      xs = coord_t'($urandom);
      ys = coord_t'($urandom);
      xe = offset_coord(xs, int'($urandom_range(0, 2*reach)) - reach);
      ye = offset_coord(ys, int'($urandom_range(0, 2*reach)) - reach);
    end
    span = (abs_diff(xs, xe) > abs_diff(ys, ye)) ? abs_diff(xs, xe) : abs_diff(ys, ye);
    pick = $urandom_range(0, 99);
    if (pick < 12)
      steps = $urandom_range(0, span);          // abandoned by the next start
    else if (pick < 22)
      steps = span + $urandom_range(1, 3);      // requests past the final endpoint
    else
      steps = span;
    if (steps > budget - 1)
      steps = budget - 1;
    send_start(xs, ys, xe, ye);
    repeat (steps) send_next();
  endtask

  // Output side: stalls drawn per word, every accepted word is checked.
  initial begin
    while (rst) @(posedge clk);
    forever begin : take_words
      int stall;
      stall = draw_wait(m_run, m_calm);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      trace.check_word(m_tdata, m_tuser, m_tlast);
    end
  end

  initial begin : stimulus
    int  goal;
    bit  paused;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Next request right after reset: no line is active.
    send_next();
    // Single points at both corners, then a request after the line has ended.
    send_start('0, '0, '0, '0);
    send_start(coord_t'(COORD_MAX), coord_t'(COORD_MAX), coord_t'(COORD_MAX),
               coord_t'(COORD_MAX));
    send_next();
    // Horizontal at the right edge, vertical going down from the top edge.
    send_start(coord_t'(COORD_MAX - 3), '0, coord_t'(COORD_MAX), '0);
    repeat (3) send_next();
    send_start(10'd3, coord_t'(COORD_MAX), 10'd3, coord_t'(COORD_MAX - 3));
    repeat (3) send_next();
    // Equal deltas: a diagonal toward lower x and higher y.
    send_start(coord_t'(COORD_MAX), coord_t'(COORD_MAX - 2), coord_t'(COORD_MAX - 2),
               coord_t'(COORD_MAX));
    repeat (2) send_next();
    // A shallow line cut short by a new start, which is steep and runs past its end.
    send_start('0, '0, 10'd5, 10'd2);
    repeat (2) send_next();
    send_start(10'd10, 10'd10, 10'd8, 10'd15);
    repeat (6) send_next();
    hold_until_drained();

    paused = 0;
    goal   = words_sent + RAND_WORDS;
    while (words_sent < goal) begin
      if (!paused && words_sent >= goal - RAND_WORDS / 2) begin
        hold_until_drained();
        paused = 1;
      end
      if ($urandom_range(0, 99) < 8)
        send_next();
      else
        send_random_line(goal - words_sent);
    end
    s_tvalid <= 1'b0;

    while (trace.pending_pixels.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (trace.errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

[line_pixel_stepper_core.f]
rtl/lps_pkg.sv
rtl/lps_front.sv
rtl/lps_fifo.sv
rtl/lps_back.sv
rtl/line_pixel_stepper_core.sv
sim/tb_line_pixel_stepper_core.sv
